// File: rtl/tlvsp_pkg.sv
// ----------------------------------------------------------------------------
// tlvsp_pkg
// Types and constants that the TLV stream parser modules share.
// ----------------------------------------------------------------------------
package tlvsp_pkg;

   localparam int unsigned ID_W     = 16;
   localparam int unsigned LEN_W    = 24;
   localparam int unsigned HCOUNT_W = 3;

   typedef enum logic [2:0] {
      PH_TYPE = 3'd0,
      PH_IDHI = 3'd1,
      PH_IDLO = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4
   } tlvsp_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } tlvsp_req_type;

   typedef struct packed {
      logic [1:0]       element_type;
      logic [ID_W-1:0]  element_id;
      logic [LEN_W-1:0] element_length;
      logic [2:0]       header_length;
      logic             header_done;
      logic             is_value;
      logic [7:0]       value_byte;
      logic             value_last;
      logic             truncated;
   } tlvsp_rsp_type;

   typedef struct packed {
      tlvsp_phase_type     phase;
      logic [1:0]          held_type;
      logic                wide_id;
      logic [ID_W-1:0]     id_accum;
      logic [1:0]          length_bytes_left;
      logic [LEN_W-1:0]    length_accum;
      logic [LEN_W-1:0]    payload_left;
      logic [HCOUNT_W-1:0] header_count;
   } tlvsp_state_type;

   localparam tlvsp_state_type STATE_RESET = '{
      phase:             PH_TYPE,
      held_type:         2'd0,
      wide_id:           1'b0,
      id_accum:          '0,
      length_bytes_left: 2'd0,
      length_accum:      '0,
      payload_left:      '0,
      header_count:      '0
   };

endpackage

// File: rtl/tlvsp_decode.sv
// ----------------------------------------------------------------------------
// tlvsp_decode
// One-byte step of the TLV decoder: next parser state and the result beat.
// ----------------------------------------------------------------------------
module tlvsp_decode
   import tlvsp_pkg::*;
(
   input  tlvsp_state_type cur_state,
   input  tlvsp_req_type   req_beat,
   output tlvsp_state_type nxt_state,
   output tlvsp_rsp_type   rsp_beat
);

   logic [7:0] b;
   logic       hdone;
   logic [2:0] hlen;
   logic       isval;
   logic [7:0] vbyte;
   logic       vlast;
   tlvsp_state_type st;

   assign b = req_beat.data_byte;

   always_comb begin
      st    = cur_state;
      hdone = 1'b0;
      hlen  = 3'd0;
      isval = 1'b0;
      vbyte = 8'd0;
      vlast = 1'b0;

      case (cur_state.phase)
         PH_IDHI: begin
            st.id_accum     = {b, 8'd0};
            st.header_count = HCOUNT_W'(cur_state.header_count + 3'd1);
            st.phase        = PH_IDLO;
         end
         PH_IDLO: begin
            st.id_accum     = {cur_state.id_accum[15:8], b};
            st.header_count = HCOUNT_W'(cur_state.header_count + 3'd1);
            if (cur_state.length_bytes_left == 2'd0) begin
               hdone           = 1'b1;
               hlen            = st.header_count;
               st.payload_left = st.length_accum;
               st.phase        = (st.length_accum != '0) ? PH_DATA : PH_TYPE;
            end else begin
               st.phase = PH_LEN;
            end
         end
         PH_LEN: begin
            st.length_accum      = {cur_state.length_accum[15:0], b};
            st.header_count      = HCOUNT_W'(cur_state.header_count + 3'd1);
            st.length_bytes_left = 2'(cur_state.length_bytes_left - 2'd1);
            if (st.length_bytes_left == 2'd0) begin
               hdone           = 1'b1;
               hlen            = st.header_count;
               st.payload_left = st.length_accum;
               st.phase        = (st.length_accum != '0) ? PH_DATA : PH_TYPE;
            end
         end
         PH_DATA: begin
            isval           = 1'b1;
            vbyte           = b;
            st.payload_left = LEN_W'(cur_state.payload_left - 24'd1);
            if (st.payload_left == '0) begin
               vlast    = 1'b1;
               st.phase = PH_TYPE;
            end
         end
         default: begin
            // type byte; unused phase codes land here too
            st.held_type         = b[7:6];
            st.wide_id           = b[5];
            st.length_bytes_left = b[4:3];
            st.length_accum      = (b[4:3] == 2'd0) ? {21'd0, b[2:0]} : '0;
            st.id_accum          = '0;
            st.payload_left      = '0;
            st.header_count      = 3'd1;
            st.phase             = b[5] ? PH_IDHI : PH_IDLO;
         end
      endcase

      rsp_beat.element_type   = st.held_type;
      rsp_beat.element_id     = st.id_accum;
      rsp_beat.element_length = st.length_accum;
      rsp_beat.header_length  = hlen;
      rsp_beat.header_done    = hdone;
      rsp_beat.is_value       = isval;
      rsp_beat.value_byte     = vbyte;
      rsp_beat.value_last     = vlast;
      rsp_beat.truncated      = 1'b0;

      nxt_state = st;
      // buffer ended mid-element: flag it and start over
      if (req_beat.end_of_buffer && (st.phase != PH_TYPE)) begin
         rsp_beat.truncated = 1'b1;
         nxt_state          = STATE_RESET;
      end
   end

endmodule

// File: rtl/tlvsp_out_buf.sv
// ----------------------------------------------------------------------------
// tlvsp_out_buf
// Result register with a skid stage so the decoder can take one more beat when
// the receiver stalls.
// ----------------------------------------------------------------------------
module tlvsp_out_buf
   import tlvsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  tlvsp_rsp_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output tlvsp_rsp_type out_data
);

   logic          main_valid_ff, main_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   tlvsp_rsp_type main_ff, main_in;
   tlvsp_rsp_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// File: rtl/tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// tlv_stream_parser
// Streaming TLV element decoder, one buffer byte per beat.
//
// req_ channel: one beat per byte of the TLV buffer, with end_of_buffer set
// on the buffer's last byte. rsp_ channel: exactly one result beat per input
// beat, in order. It reports the element header fields, header_done with the
// header length on the last header byte, and tags payload bytes with
// is_value and value_last.
// Each result beat is registered in the result register, via the skid register
// when the receiver stalls. Throughput is one byte per cycle while the receiver
// keeps up; the byte-step decode between state and result registers sets it.
// When the receiver stalls, one more beat is taken into a skid register and
// then req_ready drops until the receiver drains it.
// A buffer that ends inside a header or payload gives truncated on that beat
// and returns the parser to its reset state. Reset empties the result stage
// and leaves the parser waiting for a type byte.
// ----------------------------------------------------------------------------
module tlv_stream_parser
   import tlvsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  tlvsp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output tlvsp_rsp_type rsp_data
);

   tlvsp_state_type state_ff, state_in;
   tlvsp_state_type step_state;
   tlvsp_rsp_type   step_rsp;
   logic            req_fire;

   assign req_fire = req_valid && req_ready;

   tlvsp_decode u_decode (
      .cur_state (state_ff),
      .req_beat  (req_data),
      .nxt_state (step_state),
      .rsp_beat  (step_rsp)
   );

   always_comb begin
      state_in = req_fire ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   tlvsp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_trunc_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && step_rsp.truncated |=> state_ff.phase == PH_TYPE)
      else $error("parser did not restart after truncation");

   a_last_is_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value_last |-> rsp_data.is_value)
      else $error("value_last without is_value");

   a_hdr_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.header_done |->
         rsp_data.header_length >= 3'd2 && rsp_data.header_length <= 3'd6)
      else $error("header_length out of range");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(state_ff))
      else $error("parser state moved without an accepted beat");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives TLV buffers through tlv_stream_parser one byte per beat and checks
// every result beat against a byte-level decoder kept in the bench. The
// stimulus covers directed headers, truncated buffers, noise and random
// element streams, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import tlvsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200_000;

   // element type codes, type byte bits 7:6
   localparam logic [1:0] TLV_OBJ_INST  = 2'd0;
   localparam logic [1:0] TLV_RES_INST  = 2'd1;
   localparam logic [1:0] TLV_MULTI_RES = 2'd2;
   localparam logic [1:0] TLV_RES_VALUE = 2'd3;

   // length coding, type byte bits 4:3
   localparam logic [1:0] LEN_INLINE = 2'd0;
   localparam logic [1:0] LEN_FIELD1 = 2'd1;
   localparam logic [1:0] LEN_FIELD2 = 2'd2;
   localparam logic [1:0] LEN_FIELD3 = 2'd3;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   tlvsp_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   tlvsp_rsp_type rsp_data;

   tlvsp_state_type parser_st = STATE_RESET;
   tlvsp_rsp_type   pending_results[$];
   tlvsp_rsp_type   want_rsp;
   logic [7:0]      tlv_buf[$];

   int unsigned req_idle_pct = 11;
   int unsigned rsp_idle_pct = 11;
   int unsigned bytes_sent   = 0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;

   tlv_stream_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // decodes one accepted byte, advances the bench copy of the parser state
   function automatic tlvsp_rsp_type decode_byte(tlvsp_req_type r);
      tlvsp_rsp_type res;
      logic          hdr_end;
      res     = '0;
      hdr_end = 1'b0;
      case (parser_st.phase)
         PH_IDHI: begin
            parser_st.id_accum     = {r.data_byte, 8'h00};
            parser_st.header_count = parser_st.header_count + 3'd1;
            parser_st.phase        = PH_IDLO;
         end
         PH_IDLO: begin
            parser_st.id_accum     = parser_st.id_accum | {8'h00, r.data_byte};
            parser_st.header_count = parser_st.header_count + 3'd1;
            if (parser_st.length_bytes_left == 2'd0) hdr_end = 1'b1;
            else parser_st.phase = PH_LEN;
         end
         PH_LEN: begin
            parser_st.length_accum      = {parser_st.length_accum[15:0], r.data_byte};
            parser_st.header_count      = parser_st.header_count + 3'd1;
            parser_st.length_bytes_left = parser_st.length_bytes_left - 2'd1;
            if (parser_st.length_bytes_left == 2'd0) hdr_end = 1'b1;
         end
         PH_DATA: begin
            res.is_value           = 1'b1;
            res.value_byte         = r.data_byte;
            parser_st.payload_left = parser_st.payload_left - 24'd1;
            if (parser_st.payload_left == 24'd0) begin
               res.value_last  = 1'b1;
               parser_st.phase = PH_TYPE;
            end
         end
         default: begin
            parser_st.held_type         = r.data_byte[7:6];
            parser_st.wide_id           = r.data_byte[5];
            parser_st.length_bytes_left = r.data_byte[4:3];
            parser_st.length_accum      = (r.data_byte[4:3] == LEN_INLINE) ?
                                          {21'd0, r.data_byte[2:0]} : '0;
            parser_st.id_accum          = '0;
            parser_st.payload_left      = '0;
            parser_st.header_count      = 3'd1;
            parser_st.phase             = r.data_byte[5] ? PH_IDHI : PH_IDLO;
         end
      endcase
      if (hdr_end) begin
         res.header_done        = 1'b1;
         res.header_length      = parser_st.header_count;
         parser_st.payload_left = parser_st.length_accum;
         parser_st.phase        = (parser_st.length_accum != 24'd0) ? PH_DATA : PH_TYPE;
      end
      res.element_type   = parser_st.held_type;
      res.element_id     = parser_st.id_accum;
      res.element_length = parser_st.length_accum;
      if (r.end_of_buffer && parser_st.phase != PH_TYPE) begin
         res.truncated = 1'b1;
         parser_st     = STATE_RESET;
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // receiver: random stalls, compares each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            mismatches++;
         end else begin
            want_rsp = pending_results.pop_front();
            check_field("element_type", 24'(want_rsp.element_type),
                        24'(rsp_data.element_type));
            check_field("element_id", 24'(want_rsp.element_id),
                        24'(rsp_data.element_id));
            check_field("element_length", want_rsp.element_length,
                        rsp_data.element_length);
            check_field("header_length", 24'(want_rsp.header_length),
                        24'(rsp_data.header_length));
            check_field("header_done", 24'(want_rsp.header_done),
                        24'(rsp_data.header_done));
            check_field("is_value", 24'(want_rsp.is_value), 24'(rsp_data.is_value));
            check_field("value_byte", 24'(want_rsp.value_byte),
                        24'(rsp_data.value_byte));
            check_field("value_last", 24'(want_rsp.value_last),
                        24'(rsp_data.value_last));
            check_field("truncated", 24'(want_rsp.truncated),
                        24'(rsp_data.truncated));
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eob);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_buffer: eob};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(decode_byte('{data_byte: b, end_of_buffer: eob}));
      bytes_sent++;
   endtask

   // sends the staged buffer; a nonzero cut ends the buffer early at that byte
   task automatic send_buffer(input int cut);
      int n;
      n = (cut > 0 && cut < tlv_buf.size()) ? cut : tlv_buf.size();
      for (int i = 0; i < n; i++) send_byte(tlv_buf[i], i == n - 1);
      tlv_buf.delete();
   endtask

   task automatic add_element(input logic [1:0] etype, input logic wide,
                              input logic [1:0] lcode, input logic [15:0] id,
                              input logic [23:0] len, input int n_pay);
      logic [2:0] low_bits;
      // bits 2:0 carry the length only for inline coding
      low_bits = (lcode == LEN_INLINE) ? len[2:0] : 3'($urandom);
      tlv_buf.push_back({etype, wide, lcode, low_bits});
      if (wide) tlv_buf.push_back(id[15:8]);
      tlv_buf.push_back(id[7:0]);
      for (int i = int'(lcode) - 1; i >= 0; i--) tlv_buf.push_back(len[8*i +: 8]);
      repeat (n_pay) tlv_buf.push_back(8'($urandom));
   endtask

   task automatic add_random_element(input bit wild);
      logic [1:0]  lcode;
      logic [23:0] len;
      int          n_pay;
      lcode = 2'($urandom_range(0, 3));
      if (lcode == LEN_INLINE) len = 24'($urandom_range(0, 7));
      else if (wild) len = 24'($urandom) >> (8 * (3 - int'(lcode)));
      else if ($urandom_range(0, 19) == 0) len = 24'($urandom_range(0, 64));
      else len = 24'($urandom_range(0, 12));
      n_pay = (len > 24'd16) ? 16 : int'(len);
      add_element(2'($urandom), 1'($urandom), lcode, 16'($urandom), len, n_pay);
   endtask

   task automatic random_buffer();
      int kind;
      int n;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // noise: raw bytes, eob on the last one brings the parser back in step
         n = $urandom_range(1, 12);
         repeat (n) tlv_buf.push_back(8'($urandom));
         send_buffer(0);
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) add_random_element(kind < 25);
         cut = (kind < 25) ? $urandom_range(1, tlv_buf.size()) : 0;
         send_buffer(cut);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_inline_lengths();
      add_element(TLV_OBJ_INST, 1'b0, LEN_INLINE, 16'h0000, 24'd0, 0);
      add_element(TLV_RES_VALUE, 1'b1, LEN_INLINE, 16'hFFFF, 24'd1, 1);
      send_buffer(0);
   endtask

   task automatic test_length_fields();
      add_element(TLV_RES_VALUE, 1'b0, LEN_FIELD1, 16'h0007, 24'd3, 3);
      add_element(TLV_RES_INST, 1'b0, LEN_FIELD2, 16'h005A, 24'd2, 2);
      // zero length carried in a three-byte field
      add_element(TLV_MULTI_RES, 1'b1, LEN_FIELD3, 16'h8001, 24'd0, 0);
      send_buffer(0);
   endtask

   task automatic test_truncation();
      add_element(TLV_OBJ_INST, 1'b1, LEN_FIELD3, 16'h1234, 24'd0, 0);
      send_buffer(1);
      add_element(TLV_MULTI_RES, 1'b0, LEN_FIELD3, 16'h00C3, 24'hFFFFFF, 1);
      send_buffer(0);
   endtask

   task automatic test_random_buffers(input int unsigned n_bytes);
      int unsigned stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) random_buffer();
   endtask

   task automatic test_drain_pause();
      test_random_buffers(40);
      wait_for_results();
      test_random_buffers(40);
   endtask

   task automatic test_back_to_back();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_buffers(150);
      req_idle_pct = 11;
      rsp_idle_pct = 11;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_inline_lengths();
      test_length_fields();
      test_truncation();
      test_random_buffers(330);
      test_drain_pause();
      test_back_to_back();
      test_random_buffers(300);
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tlvsp_pkg.sv
rtl/tlvsp_decode.sv
rtl/tlvsp_out_buf.sv
rtl/tlv_stream_parser.sv
tb/testbench.sv
